// ===== sv/dicp_pkg.sv =====
package dicp_pkg;

  localparam int unsigned CHANNELS  = 32;
  localparam int unsigned CH_W      = 5;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 4;

  localparam logic [CFG_W-1:0] MODE_RESET = 64'h2222_2222_2222_2222;
  localparam logic [VAL_W-1:0] COUNT_MAX  = 16'd255;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 2'd2;

  // Item function codes.
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_BYPASS = 2'd2;

  // Channel mode codes.
  localparam logic [MODE_W-1:0] MODE_FORCE_LOW  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE_HIGH = 4'd1;
  localparam logic [MODE_W-1:0] MODE_DIRECT     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_INVERTED   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CNT_FALL   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CNT_RISE   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_CNT_BOTH   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TOG_FALL   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_TOG_RISE   = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic commit;    // update the channel and load the result register
  } dicp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // the result register holds an item not yet taken
  } dicp_stat_t;

endpackage

// ===== sv/dicp_if.sv =====
interface dicp_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [dicp_pkg::CH_W-1:0]     channel;
  logic                          raw_level;
  logic [dicp_pkg::VAL_W-1:0]    bypass_value;

  modport source (output valid, func, channel, raw_level, bypass_value, input ready);
  modport sink   (input valid, func, channel, raw_level, bypass_value, output ready);
endinterface

interface dicp_out_if;
  logic                          valid;
  logic                          ready;
  logic [dicp_pkg::VAL_W-1:0]    channel_value;
  logic                          edge_detected;

  modport source (output valid, channel_value, edge_detected, input ready);
  modport sink   (input valid, channel_value, edge_detected, output ready);
endinterface

// ===== sv/dicp_ctrl.sv =====
module dicp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dicp_pkg::dicp_stat_t stat_i,
  output dicp_pkg::dicp_cmd_t  cmd_o
);
  import dicp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Commit only once the result register can take the new result.
        if (!stat_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/dicp_dp.sv =====
module dicp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dicp_pkg::dicp_cmd_t               cmd_i,
  output dicp_pkg::dicp_stat_t              stat_o,
  input  logic                              cfg_we_i,
  input  logic [dicp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dicp_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [1:0]                        func_i,
  input  logic [dicp_pkg::CH_W-1:0]         channel_i,
  input  logic                              raw_level_i,
  input  logic [dicp_pkg::VAL_W-1:0]        bypass_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dicp_pkg::VAL_W-1:0]        channel_value_o,
  output logic                              edge_detected_o
);
  import dicp_pkg::*;

  logic [CFG_W-1:0]    mode_low_q, mode_high_q;
  logic [CHANNELS-1:0] bypass_q;

  logic [VAL_W-1:0]    store_q [CHANNELS];
  logic [CHANNELS-1:0] prev_q;

  logic [1:0]          func_q;
  logic [CH_W-1:0]     ch_q;
  logic                lvl_q;
  logic [VAL_W-1:0]    bval_q;

  logic                out_valid_q;
  logic [VAL_W-1:0]    out_val_q;
  logic                out_edge_q;

  logic                in_range;
  logic [MODE_W-1:0]   mode;
  logic                bypassed;
  logic [VAL_W-1:0]    cur_val;
  logic                prev;
  logic                fall, rise, counting;
  logic [VAL_W-1:0]    new_val;
  logic                new_prev;
  logic                hit;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_low_q  <= MODE_RESET;
      mode_high_q <= MODE_RESET;
      bypass_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE_LOW:  mode_low_q  <= cfg_data_i;
        REG_MODE_HIGH: mode_high_q <= cfg_data_i;
        REG_BYPASS:    bypass_q    <= cfg_data_i[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  // Item register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      ch_q   <= channel_i;
      lvl_q  <= raw_level_i;
      bval_q <= bypass_value_i;
    end
  end

  assign in_range = ({1'b0, ch_q} < (CH_W + 1)'(CHANNELS));
  assign mode     = ch_q[CH_W-1] ? mode_high_q[ch_q[CH_W-2:0]*MODE_W +: MODE_W]
                                 : mode_low_q[ch_q[CH_W-2:0]*MODE_W +: MODE_W];
  assign bypassed = bypass_q[ch_q];
  assign cur_val  = store_q[ch_q];
  assign prev     = prev_q[ch_q];
  assign fall     = prev && !lvl_q;
  assign rise     = !prev && lvl_q;
  assign counting = (mode == MODE_CNT_FALL) || (mode == MODE_CNT_RISE) ||
                    (mode == MODE_CNT_BOTH);

  always_comb begin
    new_val  = cur_val;
    new_prev = prev;
    hit      = 1'b0;
    case (func_q)
      FUNC_SAMPLE: begin
        if (!bypassed) begin
          case (mode)
            MODE_FORCE_LOW:  new_val = '0;
            MODE_FORCE_HIGH: new_val = VAL_W'(1);
            MODE_DIRECT:     new_val = VAL_W'(lvl_q);
            MODE_INVERTED:   new_val = VAL_W'(!lvl_q);
            MODE_CNT_FALL, MODE_CNT_RISE, MODE_CNT_BOTH: begin
              hit = ((mode == MODE_CNT_FALL) && fall) ||
                    ((mode == MODE_CNT_RISE) && rise) ||
                    ((mode == MODE_CNT_BOTH) && (fall || rise));
              if (hit && (cur_val < COUNT_MAX)) begin
                new_val = cur_val + VAL_W'(1);
              end
              new_prev = lvl_q;
            end
            MODE_TOG_FALL, MODE_TOG_RISE: begin
              if (((mode == MODE_TOG_FALL) && fall) || ((mode == MODE_TOG_RISE) && rise)) begin
                new_val = (cur_val == '0) ? VAL_W'(1) : '0;
              end
              new_prev = lvl_q;
            end
            default: ;
          endcase
        end
      end
      FUNC_CLEAR: begin
        if (counting) begin
          new_val = '0;
        end
      end
      FUNC_BYPASS: begin
        if (bypassed) begin
          new_val = bval_q;
        end
      end
      default: ;
    endcase
  end

  // Channel state, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        store_q[i] <= '0;
      end
      prev_q <= '0;
    end else if (cmd_i.commit && in_range) begin
      store_q[ch_q] <= new_val;
      prev_q[ch_q]  <= new_prev;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_val_q  <= in_range ? new_val : '0;
      out_edge_q <= in_range && hit;
    end
  end

  assign stat_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign channel_value_o    = out_val_q;
  assign edge_detected_o    = out_edge_q;

endmodule

// ===== sv/discrete_input_channel_processor.sv =====
// Timing: an accepted item is captured in the item register; the commit step then
// loads its result into the result register, which offers it on the output.
// Flow: the controller takes an item in its idle state and commits it in its exec state,
// taking no new item meanwhile; a commit waits while an earlier result is not yet taken.
// The result register lets the next item enter while a result waits to be taken.
// Reset: asynchronous, active low; modes return to direct, bypass clears, and all
// channel values and previous levels are zero at once, with no clearing pass.
module discrete_input_channel_processor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dicp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dicp_pkg::CFG_W-1:0]        cfg_data_i,
  dicp_in_if.sink                           in_if,
  dicp_out_if.source                        out_if
);
  import dicp_pkg::*;

  // The controller decides when an item is taken and when it is committed;
  // the datapath holds the configuration, the channel store and the result.
  dicp_cmd_t  cmd;
  dicp_stat_t stat;

  dicp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The commit step reads the addressed channel, applies the mode or the item's
  // function, writes the channel back and loads the result register together.
  dicp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (in_if.func),
    .channel_i       (in_if.channel),
    .raw_level_i     (in_if.raw_level),
    .bypass_value_i  (in_if.bypass_value),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .channel_value_o (out_if.channel_value),
    .edge_detected_o (out_if.edge_detected)
  );

endmodule

// ===== verif/discrete_input_channel_processor_tb.sv =====
module discrete_input_channel_processor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dicp_pkg::*;

  // The item function code that the block must treat as a no-op.
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [CH_W-1:0]  channel;
    logic             raw_level;
    logic [VAL_W-1:0] bypass_value;
  } chan_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] channel_value;
    logic             edge_detected;
  } chan_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  dicp_in_if  in_bus ();
  dicp_out_if out_bus ();

  discrete_input_channel_processor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  // 4 ns clock period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Items waiting to be offered to the block, and results predicted for
  // items the block has already accepted, oldest first.
  chan_item_t   pending_items [$];
  chan_result_t expected_results [$];
  int unsigned  error_count = 0;

  // Our own copy of the block's configuration and per-channel state.
  logic [CFG_W-1:0] model_mode_low;
  logic [CFG_W-1:0] model_mode_high;
  logic [31:0]      model_bypass;
  logic             model_level_prev [CHANNELS];
  logic [VAL_W-1:0] model_value [CHANNELS];

  // Last level the stimulus sent per channel, so that samples mostly alternate
  // and the edge and toggle modes see real transitions.
  logic stim_level [CHANNELS];

  // Applies one accepted item to the channel state and returns the result the
  // block has to produce for it.
  function automatic chan_result_t predict_channel_item(input chan_item_t it);
    chan_result_t     res;
    logic [MODE_W-1:0] mode;
    logic             bypassed;
    logic             prev;
    logic             fall;
    logic             rise;
    logic             hit;
    int unsigned      ch;

    ch = it.channel;
    res.edge_detected = 1'b0;
    bypassed = model_bypass[ch];
    if (it.channel[4]) begin
      mode = model_mode_high[{it.channel[3:0], 2'b00} +: MODE_W];
    end else begin
      mode = model_mode_low[{it.channel[3:0], 2'b00} +: MODE_W];
    end
    prev = model_level_prev[ch];
    fall = prev && !it.raw_level;
    rise = !prev && it.raw_level;

    case (it.func)
      FUNC_SAMPLE: begin
        // A bypassed channel ignores its samples entirely.
        if (!bypassed) begin
          case (mode)
            MODE_FORCE_LOW:  model_value[ch] = '0;
            MODE_FORCE_HIGH: model_value[ch] = VAL_W'(1);
            MODE_DIRECT:     model_value[ch] = VAL_W'(it.raw_level);
            MODE_INVERTED:   model_value[ch] = VAL_W'(!it.raw_level);
            MODE_CNT_FALL, MODE_CNT_RISE, MODE_CNT_BOTH: begin
              hit = (mode == MODE_CNT_FALL && fall) || (mode == MODE_CNT_RISE && rise) ||
                    (mode == MODE_CNT_BOTH && (fall || rise));
              if (hit) begin
                res.edge_detected = 1'b1;
                // The count saturates instead of wrapping.
                if (model_value[ch] < COUNT_MAX) model_value[ch] = model_value[ch] + 1'b1;
              end
              model_level_prev[ch] = it.raw_level;
            end
            MODE_TOG_FALL, MODE_TOG_RISE: begin
              if ((mode == MODE_TOG_FALL && fall) || (mode == MODE_TOG_RISE && rise)) begin
                model_value[ch] = (model_value[ch] == '0) ? VAL_W'(1) : '0;
              end
              model_level_prev[ch] = it.raw_level;
            end
            default: begin
              // Unknown mode codes leave the channel untouched.
            end
          endcase
        end
      end
      FUNC_CLEAR: begin
        // Clearing only acts in the counting modes, bypassed or not.
        if (mode == MODE_CNT_FALL || mode == MODE_CNT_RISE || mode == MODE_CNT_BOTH) begin
          model_value[ch] = '0;
        end
      end
      FUNC_BYPASS: begin
        if (bypassed) model_value[ch] = it.bypass_value;
      end
      default: begin
        // The reserved function code only reports the current value.
      end
    endcase

    res.channel_value = model_value[ch];
    return res;
  endfunction

  // Sender. Items go out in bursts of random length separated by random gaps;
  // a gap of zero keeps the stream back to back.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : item_driver
    chan_item_t  nxt_item;
    logic        nxt_valid;
    int unsigned sel;

    nxt_valid = in_bus.valid;
    nxt_item.func         = in_bus.func;
    nxt_item.channel      = in_bus.channel;
    nxt_item.raw_level    = in_bus.raw_level;
    nxt_item.bypass_value = in_bus.bypass_value;
    if (rst_ni && (!in_bus.valid || in_bus.ready)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        nxt_item  = pending_items.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          sel = $urandom_range(0, 9);
          if (sel < 5) gap_left = 0;
          else if (sel < 9) gap_left = $urandom_range(1, 4);
          else gap_left = $urandom_range(10, 25);
        end
      end
    end
    in_bus.valid        <= nxt_valid;
    in_bus.func         <= nxt_item.func;
    in_bus.channel      <= nxt_item.channel;
    in_bus.raw_level    <= nxt_item.raw_level;
    in_bus.bypass_value <= nxt_item.bypass_value;
  end

  // Receiver. Ready follows one of several patterns, each held for a random
  // stretch: always ready, a fixed two-in-five rhythm, coin flips, and rare
  // acceptance for heavy backpressure.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk_i) begin : result_receiver
    logic nxt_ready;

    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 200);
    end else begin
      stall_left--;
    end
    stall_tick = (stall_tick == 4) ? 0 : stall_tick + 1;
    case (stall_mode)
      0:       nxt_ready = 1'b1;
      1:       nxt_ready = (stall_tick < 2);
      2:       nxt_ready = $urandom_range(0, 1);
      default: nxt_ready = ($urandom_range(0, 7) == 0);
    endcase
    out_bus.ready <= nxt_ready;
  end

  // Monitor. At each edge it first checks a delivered result against the
  // oldest prediction, then predicts the result of an item accepted at the
  // same edge. The block's latency keeps an item and its own result apart.
  always @(posedge clk_i) begin : result_monitor
    chan_result_t got;
    chan_result_t want;
    chan_item_t   acc;

    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got.channel_value = out_bus.channel_value;
        got.edge_detected = out_bus.edge_detected;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: channel_value %0h edge_detected %0b",
                 got.channel_value, got.edge_detected);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.channel_value !== want.channel_value) begin
            $error("channel_value mismatch: expected %0h, actual %0h",
                   want.channel_value, got.channel_value);
            error_count++;
          end
          if (got.edge_detected !== want.edge_detected) begin
            $error("edge_detected mismatch: expected %0b, actual %0b",
                   want.edge_detected, got.edge_detected);
            error_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        acc.func         = in_bus.func;
        acc.channel      = in_bus.channel;
        acc.raw_level    = in_bus.raw_level;
        acc.bypass_value = in_bus.bypass_value;
        expected_results.push_back(predict_channel_item(acc));
      end
    end
  end

  task automatic push_item(input logic [1:0] func, input int unsigned ch, input logic lvl,
                           input logic [VAL_W-1:0] bval);
    chan_item_t it;

    it.func         = func;
    it.channel      = CH_W'(ch);
    it.raw_level    = lvl;
    it.bypass_value = bval;
    if (func == FUNC_SAMPLE) stim_level[ch] = lvl;
    pending_items.push_back(it);
  endtask

  // Sampled at the falling edge, where every driven value has settled.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_bus.valid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE_LOW:  model_mode_low = data;
      REG_MODE_HIGH: model_mode_high = data;
      REG_BYPASS:    model_bypass = data[31:0];
      default: ;
    endcase
  endtask

  // Reprograms all registers. Only called once the block has gone idle; the
  // extra cycles cover the pipeline beyond the last delivered result.
  task automatic set_config(input logic [CFG_W-1:0] mode_low, input logic [CFG_W-1:0] mode_high,
                            input logic [31:0] bypass);
    wait_idle();
    repeat (3) @(posedge clk_i);
    write_reg(REG_MODE_LOW, mode_low);
    write_reg(REG_MODE_HIGH, mode_high);
    write_reg(REG_BYPASS, CFG_W'(bypass));
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] random_known_modes();
    logic [CFG_W-1:0] word;

    for (int i = 0; i < 16; i++) begin
      word[4*i +: 4] = MODE_W'($urandom_range(0, 8));
    end
    return word;
  endfunction

  // Mostly well-formed traffic: samples that alternate per channel, clears and
  // bypass writes, with a little noise from random levels and the reserved
  // function code. A few channels get extra traffic so counts grow deep.
  // Halfway through, the sender waits until every result is back.
  task automatic random_phase(input int unsigned count);
    int unsigned hot [4];
    int unsigned pick;
    int unsigned ch;
    logic        lvl;
    logic [VAL_W-1:0] bval;

    for (int i = 0; i < 4; i++) hot[i] = $urandom_range(0, CHANNELS - 1);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) wait_idle();
      ch = ($urandom_range(0, 9) < 6) ? $urandom_range(0, CHANNELS - 1) : hot[$urandom_range(0, 3)];
      pick = $urandom_range(0, 99);
      lvl  = ($urandom_range(0, 4) != 0) ? !stim_level[ch] : 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       bval = '0;
        1:       bval = '1;
        default: bval = VAL_W'($urandom);
      endcase
      if (pick < 68) push_item(FUNC_SAMPLE, ch, lvl, bval);
      else if (pick < 78) push_item(FUNC_CLEAR, ch, lvl, bval);
      else if (pick < 94) push_item(FUNC_BYPASS, ch, lvl, bval);
      else push_item(FUNC_RESERVED, ch, lvl, bval);
    end
  endtask

  initial begin : stimulus
    int unsigned ch;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    in_bus.valid         = 1'b0;
    in_bus.func          = FUNC_SAMPLE;
    in_bus.channel       = '0;
    in_bus.raw_level     = 1'b0;
    in_bus.bypass_value  = '0;
    out_bus.ready        = 1'b0;
    model_mode_low       = MODE_RESET;
    model_mode_high      = MODE_RESET;
    model_bypass         = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      model_level_prev[i] = 1'b0;
      model_value[i]      = '0;
      stim_level[i]       = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: every channel direct, nothing bypassed. A clear
    // outside the counting modes and a bypass write without bypass do nothing.
    push_item(FUNC_SAMPLE, 0, 1'b1, '0);
    push_item(FUNC_SAMPLE, 0, 1'b0, '1);
    push_item(FUNC_SAMPLE, CHANNELS - 1, 1'b1, '0);
    push_item(FUNC_CLEAR, CHANNELS - 1, 1'b0, '0);
    push_item(FUNC_BYPASS, 0, 1'b0, '1);
    push_item(FUNC_RESERVED, CHANNELS - 1, 1'b1, '1);

    // Channels 0 to 8 cover every mode, 16 to 23 all but force low; 9, 10
    // and 24 up carry unknown codes. Channel 5 (rising count) and 31 are bypassed.
    set_config(64'h8765_4F98_7654_3210, 64'hFFFF_FFFF_8765_4321, 32'h8000_0020);
    push_item(FUNC_SAMPLE, 0, 1'b1, '0);
    push_item(FUNC_SAMPLE, 1, 1'b0, '0);
    push_item(FUNC_SAMPLE, 2, 1'b1, '0);
    push_item(FUNC_SAMPLE, 3, 1'b1, '0);
    push_item(FUNC_SAMPLE, 4, 1'b1, '0);
    push_item(FUNC_SAMPLE, 4, 1'b0, '0);
    push_item(FUNC_SAMPLE, 6, 1'b1, '0);
    push_item(FUNC_SAMPLE, 6, 1'b0, '0);
    push_item(FUNC_SAMPLE, 7, 1'b1, '0);
    push_item(FUNC_SAMPLE, 7, 1'b0, '0);
    push_item(FUNC_SAMPLE, 8, 1'b1, '0);
    push_item(FUNC_SAMPLE, 9, 1'b1, '0);
    push_item(FUNC_SAMPLE, 10, 1'b1, '0);
    push_item(FUNC_CLEAR, 4, 1'b0, '0);
    push_item(FUNC_CLEAR, 2, 1'b0, '0);
    push_item(FUNC_CLEAR, 9, 1'b0, '0);
    push_item(FUNC_SAMPLE, 5, 1'b1, '0);
    push_item(FUNC_BYPASS, 5, 1'b0, '1);
    push_item(FUNC_CLEAR, 5, 1'b0, '0);
    push_item(FUNC_BYPASS, CHANNELS - 1, 1'b0, '1);
    push_item(FUNC_BYPASS, CHANNELS - 1, 1'b0, '0);
    push_item(FUNC_BYPASS, 0, 1'b0, 16'h1234);
    push_item(FUNC_RESERVED, 6, 1'b0, '1);

    // Drive two both-edge channels through enough transitions to hit the
    // count ceiling, then clear them and count again.
    set_config(64'h6666_6666_6666_6666, 64'h6666_6666_6666_6666, 32'h0);
    push_item(FUNC_CLEAR, 3, 1'b0, '0);
    push_item(FUNC_CLEAR, 20, 1'b0, '0);
    for (int k = 0; k < 280; k++) begin
      ch = $urandom_range(0, 1) ? 3 : 20;
      push_item(FUNC_SAMPLE, ch, !stim_level[ch], '0);
      ch = (ch == 3) ? 20 : 3;
      push_item(FUNC_SAMPLE, ch, !stim_level[ch], '0);
    end
    push_item(FUNC_CLEAR, 3, 1'b0, '0);
    push_item(FUNC_CLEAR, 20, 1'b0, '0);
    push_item(FUNC_SAMPLE, 3, !stim_level[3], '0);
    push_item(FUNC_SAMPLE, 20, !stim_level[20], '0);

    // Random traffic over a series of settings, extremes among them.
    set_config(random_known_modes(), random_known_modes(), $urandom);
    random_phase(200);
    set_config('1, '0, 32'hFFFF_FFFF);
    random_phase(200);
    set_config('0, '1, 32'h0);
    random_phase(200);
    set_config({$urandom, $urandom}, {$urandom, $urandom}, $urandom & $urandom);
    random_phase(200);
    set_config(random_known_modes(), random_known_modes(), 32'h0);
    random_phase(200);
    set_config(MODE_RESET, MODE_RESET, 32'hFFFF_0000);
    random_phase(200);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Far beyond the slowest legitimate run.
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
